// ----- src/planar_ham_ehb_pixel_decoder_core_macros.svh -----
// Assertion macros shared by the pixel decoder RTL.
`ifndef PLANAR_HAM_EHB_PIXEL_DECODER_CORE_MACROS_SVH
`define PLANAR_HAM_EHB_PIXEL_DECODER_CORE_MACROS_SVH

// Check a property on every rising edge outside reset.
`define PHD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check that a condition never holds outside reset.
`define PHD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `PHD_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// ----- src/phd_pkg.sv -----
// Shared types and constants of the planar pixel decoder.
package phd_pkg;

  localparam int unsigned PAL_ENTRIES = 256;
  localparam int unsigned PAL_AW      = $clog2(PAL_ENTRIES);
  localparam logic [8:0]  PAL_LIMIT   = 9'(PAL_ENTRIES);

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_WIDTH = 2'd2;

  localparam logic [2:0] MODE_INDEXED   = 3'd0;
  localparam logic [2:0] MODE_HALFBRITE = 3'd1;
  localparam logic [2:0] MODE_HAM6      = 3'd2;
  localparam logic [2:0] MODE_HAM8      = 3'd3;
  localparam logic [2:0] MODE_DIRECT    = 3'd4;

  localparam logic [1:0] HAM_LOAD  = 2'd0;
  localparam logic [1:0] HAM_BLUE  = 2'd1;
  localparam logic [1:0] HAM_RED   = 2'd2;
  localparam logic [1:0] HAM_GREEN = 2'd3;

  localparam logic [3:0] PLANES_MAX = 4'd8;

  typedef enum logic [2:0] {
    OP_COLOUR = 3'd0,
    OP_LOAD   = 3'd1,
    OP_MOD_R  = 3'd2,
    OP_MOD_G  = 3'd3,
    OP_MOD_B  = 3'd4
  } op_e;

  typedef struct packed {
    logic [2:0] color_mode;
    logic [3:0] plane_count;
    logic       double_width;
  } cfg_t;

  typedef struct packed {
    op_e         op;
    logic [23:0] colour;
    logic [7:0]  mod_val;
    logic        keep_low;
    logic        padding;
  } item_t;

  typedef struct packed {
    logic [Q_CW-1:0] count;
  } q_stat_t;

  typedef struct packed {
    logic rep_pending;
  } back_stat_t;

endpackage

// ----- src/phd_front.sv -----
// Front end: request intake, palette memory and pixel classification.
module phd_front import phd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        in_cmd_i,
  input  logic [23:0] in_plane_bits_i,
  input  logic        in_padding_i,
  input  logic [7:0]  in_entry_index_i,
  input  logic [23:0] in_entry_color_i,
  output logic        item_valid_o,
  output item_t       item_o,
  input  logic        item_stall_i
);

  logic [23:0] pal_mem [PAL_ENTRIES];
  logic [23:0] rd_data_q;

  logic        s1_valid_q, s1_valid_d;
  op_e         op_q, op_d;
  logic        direct_q, direct_d;
  logic [23:0] dcol_q, dcol_d;
  logic        halve_q, halve_d;
  logic        zero_q, zero_d;
  logic [7:0]  mod_q, mod_d;
  logic        keep_q, keep_d;
  logic        pad_q;

  logic        advance, accept, wr_en, rd_en;
  logic [3:0]  pc;
  logic [7:0]  mask, idx, rd_idx;
  logic [23:0] pal_col;

  assign advance    = !s1_valid_q || !item_stall_i;
  assign in_stall_o = !advance;
  assign accept     = in_valid_i && advance;
  assign wr_en      = accept && in_cmd_i && ({1'b0, in_entry_index_i} < PAL_LIMIT);
  assign rd_en      = accept && !in_cmd_i;

  assign pc   = (cfg_i.plane_count > PLANES_MAX) ? PLANES_MAX : cfg_i.plane_count;
  assign mask = 8'((9'd1 << pc) - 9'd1);
  assign idx  = in_plane_bits_i[7:0] & mask;

  always_comb begin
    rd_idx   = idx;
    op_d     = OP_COLOUR;
    direct_d = 1'b0;
    dcol_d   = {in_plane_bits_i[7:0], in_plane_bits_i[15:8], in_plane_bits_i[23:16]};
    halve_d  = 1'b0;
    mod_d    = '0;
    keep_d   = 1'b0;
    case (cfg_i.color_mode)
      MODE_HALFBRITE: begin
        rd_idx  = {3'b000, idx[4:0]};
        halve_d = idx[5];
      end
      MODE_HAM6: begin
        rd_idx = {4'b0000, idx[3:0]};
        mod_d  = {idx[3:0], idx[3:0]};
        case (idx[5:4])
          HAM_LOAD:  op_d = OP_LOAD;
          HAM_BLUE:  op_d = OP_MOD_B;
          HAM_RED:   op_d = OP_MOD_R;
          HAM_GREEN: op_d = OP_MOD_G;
          default:   op_d = OP_LOAD;
        endcase
      end
      MODE_HAM8: begin
        rd_idx = {2'b00, idx[5:0]};
        mod_d  = {idx[5:0], 2'b00};
        keep_d = 1'b1;
        case (idx[7:6])
          HAM_LOAD:  op_d = OP_LOAD;
          HAM_BLUE:  op_d = OP_MOD_B;
          HAM_RED:   op_d = OP_MOD_R;
          HAM_GREEN: op_d = OP_MOD_G;
          default:   op_d = OP_LOAD;
        endcase
      end
      MODE_DIRECT: begin
        direct_d = 1'b1;
      end
      default: begin
        rd_idx = idx;
      end
    endcase
    zero_d = ({1'b0, rd_idx} >= PAL_LIMIT);
  end

  // Palette: one write or one registered read per accepted request.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pal_mem[in_entry_index_i[PAL_AW-1:0]] <= in_entry_color_i;
    end
    if (rd_en) begin
      rd_data_q <= pal_mem[rd_idx[PAL_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      op_q     <= op_d;
      direct_q <= direct_d;
      dcol_q   <= dcol_d;
      halve_q  <= halve_d;
      zero_q   <= zero_d;
      mod_q    <= mod_d;
      keep_q   <= keep_d;
      pad_q    <= in_padding_i;
    end
  end

  assign s1_valid_d = advance ? rd_en : s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_comb begin
    if (zero_q) begin
      pal_col = '0;
    end else if (halve_q) begin
      pal_col = {1'b0, rd_data_q[23:17], 1'b0, rd_data_q[15:9], 1'b0, rd_data_q[7:1]};
    end else begin
      pal_col = rd_data_q;
    end
  end

  assign item_valid_o     = s1_valid_q;
  assign item_o.op        = op_q;
  assign item_o.colour    = direct_q ? dcol_q : pal_col;
  assign item_o.mod_val   = mod_q;
  assign item_o.keep_low  = keep_q;
  assign item_o.padding   = pad_q;

endmodule

// ----- src/phd_queue.sv -----
// Short queue of classified pixels between front and back end.
module phd_queue import phd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  item_t   in_item_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output item_t   out_item_o,
  output q_stat_t stat_o
);

  item_t           entries [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [Q_CW-1:0] count_q, count_d;
  logic            full, push, pop;

  assign full        = (count_q == Q_CW'(Q_DEPTH));
  assign in_stall_o  = full;
  assign out_valid_o = (count_q != '0);
  assign push        = in_valid_i && !full;
  assign pop         = out_valid_o && !out_stall_i;
  assign out_item_o  = entries[rd_ptr_q];

  assign stat_o.count = count_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries[wr_ptr_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ----- src/phd_back.sv -----
// Back end: held HAM colour, padding drop and output beats.
module phd_back import phd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       double_width_i,
  input  logic       item_valid_i,
  output logic       item_stall_o,
  input  item_t      item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_red_o,
  output logic [7:0] out_green_o,
  output logic [7:0] out_blue_o,
  output logic       out_last_o,
  output back_stat_t stat_o
);

  logic [7:0]  held_r_q, held_r_d, held_g_q, held_g_d, held_b_q, held_b_d;
  logic        out_valid_q, out_valid_d, last_q, last_d, rep_q, rep_d;
  logic [23:0] rgb_q, rgb_d;
  logic        out_free, pop;
  logic [23:0] res;

  assign out_free     = !out_valid_q || !out_stall_i;
  assign item_stall_o = rep_q || !out_free;
  assign pop          = item_valid_i && !item_stall_o;

  always_comb begin
    held_r_d = held_r_q;
    held_g_d = held_g_q;
    held_b_d = held_b_q;
    case (item_i.op)
      OP_LOAD: begin
        held_r_d = item_i.colour[23:16];
        held_g_d = item_i.colour[15:8];
        held_b_d = item_i.colour[7:0];
      end
      OP_MOD_R: held_r_d = item_i.keep_low ? {item_i.mod_val[7:2], held_r_q[1:0]} : item_i.mod_val;
      OP_MOD_G: held_g_d = item_i.keep_low ? {item_i.mod_val[7:2], held_g_q[1:0]} : item_i.mod_val;
      OP_MOD_B: held_b_d = item_i.keep_low ? {item_i.mod_val[7:2], held_b_q[1:0]} : item_i.mod_val;
      default: ;
    endcase
    res = (item_i.op == OP_COLOUR) ? item_i.colour : {held_r_d, held_g_d, held_b_d};
  end

  always_comb begin
    out_valid_d = out_valid_q;
    last_d      = last_q;
    rep_d       = rep_q;
    rgb_d       = rgb_q;
    if (out_free) begin
      if (rep_q) begin
        // Repeat the held beat as the closing one.
        out_valid_d = 1'b1;
        last_d      = 1'b1;
        rep_d       = 1'b0;
      end else if (pop && !item_i.padding) begin
        out_valid_d = 1'b1;
        rgb_d       = res;
        last_d      = !double_width_i;
        rep_d       = double_width_i;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rgb_q  <= rgb_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rep_q       <= 1'b0;
      held_r_q    <= '0;
      held_g_q    <= '0;
      held_b_q    <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      rep_q       <= rep_d;
      if (pop) begin
        held_r_q <= held_r_d;
        held_g_q <= held_g_d;
        held_b_q <= held_b_d;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_red_o          = rgb_q[23:16];
  assign out_green_o        = rgb_q[15:8];
  assign out_blue_o         = rgb_q[7:0];
  assign out_last_o         = last_q;
  assign stat_o.rep_pending = rep_q;

endmodule

// ----- src/planar_ham_ehb_pixel_decoder_core.sv -----
// Top level of the planar pixel decoder: config registers and pipeline wiring.
`include "planar_ham_ehb_pixel_decoder_core_macros.svh"

// Turns one pixel's bitplane bits into 8-bit red, green and blue in indexed,
// extra-halfbrite, HAM6, HAM8 or direct 24-bit mode, set by color_mode. The
// block takes one request per clock while in_stall_o is low: a request is
// either a palette write, which produces nothing, or a pixel. A visible pixel
// gives one result beat with last set, or two equal beats (last clear, then
// set) when double_width is on; a padding pixel only advances the held HAM
// colour. A request passes the registered palette read in the front end, the
// two-entry queue and the output register of the back end. Sustained rate is
// one pixel per clock while the output is not stalled; with width doubling
// the back end takes no new pixel until its repeat beat has been issued, as
// the output register paces it. A palette entry written by one request is seen by a
// pixel taken in the very next cycle. Palette entries must be written before
// they are read; they have no reset. The held HAM colour resets to black and
// is kept across rows. Write the configuration registers only while the
// block is idle.
module planar_ham_ehb_pixel_decoder_core import phd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  in_cmd_i,
  input  logic [23:0]           in_plane_bits_i,
  input  logic                  in_padding_i,
  input  logic [7:0]            in_entry_index_i,
  input  logic [23:0]           in_entry_color_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            out_red_o,
  output logic [7:0]            out_green_o,
  output logic [7:0]            out_blue_o,
  output logic                  out_last_o
);

  cfg_t       cfg_q;
  logic       f_valid, f_stall, b_valid, b_stall;
  item_t      f_item, b_item;
  q_stat_t    q_stat;
  back_stat_t b_stat;

  // Configuration registers; writes to an unused index are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.color_mode   <= MODE_INDEXED;
      cfg_q.plane_count  <= PLANES_MAX;
      cfg_q.double_width <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COLOR_MODE:   cfg_q.color_mode   <= cfg_wdata_i[2:0];
        CFG_PLANE_COUNT:  cfg_q.plane_count  <= cfg_wdata_i[3:0];
        CFG_DOUBLE_WIDTH: cfg_q.double_width <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Front end: take requests, write or read the palette, classify pixels.
  phd_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_cmd_i         (in_cmd_i),
    .in_plane_bits_i  (in_plane_bits_i),
    .in_padding_i     (in_padding_i),
    .in_entry_index_i (in_entry_index_i),
    .in_entry_color_i (in_entry_color_i),
    .item_valid_o     (f_valid),
    .item_o           (f_item),
    .item_stall_i     (f_stall)
  );

  // Decouple the two ends so that an output stall does not block intake at once.
  phd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_stall_o  (f_stall),
    .in_item_i   (f_item),
    .out_valid_o (b_valid),
    .out_stall_i (b_stall),
    .out_item_o  (b_item),
    .stat_o      (q_stat)
  );

  // Back end: apply HAM updates, drop padding, emit one or two beats.
  phd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .double_width_i (cfg_q.double_width),
    .item_valid_i   (b_valid),
    .item_stall_o   (b_stall),
    .item_i         (b_item),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_red_o      (out_red_o),
    .out_green_o    (out_green_o),
    .out_blue_o     (out_blue_o),
    .out_last_o     (out_last_o),
    .stat_o         (b_stat)
  );

  // A pending repeat beat always sits behind a valid output.
  `PHD_ASSERT(a_rep_has_beat, clk_i, rst_ni, b_stat.rep_pending |-> out_valid_o, "repeat without beat")
  // A taken first beat is followed by its closing twin.
  `PHD_ASSERT(a_twin_beat, clk_i, rst_ni, (out_valid_o && !out_stall_i && !out_last_o) |=> (out_valid_o && out_last_o && out_red_o == $past(out_red_o) && out_green_o == $past(out_green_o) && out_blue_o == $past(out_blue_o)), "second beat differs")
  // Only width doubling produces a beat that is not the last.
  `PHD_ASSERT_NEVER(a_first_only_doubled, clk_i, rst_ni, out_valid_o && !out_last_o && !cfg_q.double_width, "first beat without doubling")
  // The queue never holds more than its depth.
  `PHD_ASSERT_NEVER(a_queue_bound, clk_i, rst_ni, q_stat.count > Q_CW'(Q_DEPTH), "queue overfilled")

endmodule
